// ----- hw/rtl/mmcr_pkg.sv -----
// Shared constants and types for the Mueller-Muller clock recovery block.
// Used by mmcr_ctrl, mmcr_dp and the top level; no dependencies.
package mmcr_pkg;

  localparam int unsigned HistoryDepth = 8;
  localparam int unsigned NewTap       = (HistoryDepth >= 2) ? HistoryDepth - 2 : 0;
  localparam int unsigned MaxSymbols   = 4;
  localparam int unsigned CntW         = $clog2(MaxSymbols + 1);

  localparam logic [22:0] OmegaMax = 23'h7FFFFF;
  localparam logic signed [19:0] OneQ14 = 20'sd16384;

  // Configuration register indexes
  localparam logic [2:0] RegComplexMode  = 3'd0;
  localparam logic [2:0] RegMuInitial    = 3'd1;
  localparam logic [2:0] RegOmegaInitial = 3'd2;
  localparam logic [2:0] RegOmegaGain    = 3'd3;
  localparam logic [2:0] RegMuGain       = 3'd4;
  localparam logic [2:0] RegOmegaLimit   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_START, ST_MI, ST_MQ, ST_SQ, ST_EVAL,
    ST_LIM, ST_OG, ST_OUPD, ST_MU, ST_ADV, ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MUL_INTI, MUL_INTQ, MUL_LIM, MUL_OG, MUL_MU
  } mul_op_e;

  typedef struct packed {
    logic    accept;
    logic    skip_dec;
    logic    start;
    logic    mul_en;
    mul_op_e mul_op;
    logic    lat_si;
    logic    lat_sq;
    logic    eval;
    logic    lat_lim;
    logic    om_upd;
    logic    adv;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic skip_nz;
    logic tick_full;
    logic out_free;
    logic last;
  } status_t;

endpackage

// ----- hw/rtl/mmcr_ctrl.sv -----
// Sequencer for the clock recovery block: walks each symbol through the
// shared multiplier steps. Depends on mmcr_pkg.
module mmcr_ctrl import mmcr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_START;
      ST_START: state_d = status_i.skip_nz ? ST_IDLE : ST_MI;
      ST_MI:    state_d = ST_MQ;
      ST_MQ:    state_d = ST_SQ;
      ST_SQ:    state_d = ST_EVAL;
      ST_EVAL:  state_d = status_i.tick_full ? ST_LIM : ST_MU;
      ST_LIM:   state_d = ST_OG;
      ST_OG:    state_d = ST_OUPD;
      ST_OUPD:  state_d = ST_MU;
      ST_MU:    state_d = ST_ADV;
      ST_ADV:   state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.out_free) state_d = status_i.last ? ST_IDLE : ST_MI;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.mul_op = MUL_INTI;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_START: begin
        cmd_o.skip_dec = status_i.skip_nz;
        cmd_o.start    = 1'b1;
      end
      ST_MI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_INTI;
      end
      ST_MQ: begin
        cmd_o.lat_si = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_INTQ;
      end
      ST_SQ:   cmd_o.lat_sq = 1'b1;
      ST_EVAL: cmd_o.eval = 1'b1;
      ST_LIM: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_LIM;
      end
      ST_OG: begin
        cmd_o.lat_lim = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_op  = MUL_OG;
      end
      ST_OUPD: cmd_o.om_upd = 1'b1;
      ST_MU: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = MUL_MU;
      end
      ST_ADV:  cmd_o.adv = 1'b1;
      ST_EMIT: cmd_o.emit = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- hw/rtl/mmcr_dp.sv -----
// Datapath of the clock recovery block: history line, shared multiplier,
// loop state, configuration registers and output register. Uses mmcr_pkg.
module mmcr_dp import mmcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output status_t            status_o,
  input  logic signed [15:0] sample_i_i,
  input  logic signed [15:0] sample_q_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] symbol_i_o,
  output logic signed [15:0] symbol_q_o,
  output logic               last_of_run_o
);

  logic        complex_q;
  logic [15:0] freq_gain_q, mu_gain_q, limit_q;
  logic [22:0] omega_init_q;

  logic [31:0] hist_q [HistoryDepth];
  logic [15:0] frac_q;
  logic [22:0] step_q;
  logic [7:0]  skip_q;
  logic [2:0]  tick_q;
  logic [31:0] psym_q [2];
  logic [1:0]  pdec_q [2];
  logic signed [15:0] lastr_q;

  logic signed [42:0] prod_q;
  logic signed [15:0] si_q, sq_q, err_q;
  logic [22:0]        lim_q;
  logic               adv_pos_q;
  logic [7:0]         skip_cand_q;
  logic [CntW-1:0]    cnt_q;

  logic               out_valid_q, last_q;
  logic signed [15:0] sym_i_q, sym_q_q;

  // Sample pair
  logic signed [15:0] ai, aq, bi, bq;
  assign ai = hist_q[HistoryDepth-1][15:0];
  assign aq = hist_q[HistoryDepth-1][31:16];
  assign bi = hist_q[NewTap][15:0];
  assign bq = hist_q[NewTap][31:16];

  // Shared multiplier operands
  logic signed [16:0] di, dq;
  logic signed [24:0] ma;
  logic signed [17:0] mb;
  assign di = {bi[15], bi} - {ai[15], ai};
  assign dq = {bq[15], bq} - {aq[15], aq};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mul_op)
      MUL_INTI: begin ma = 25'(di); mb = {2'b00, frac_q}; end
      MUL_INTQ: begin ma = 25'(dq); mb = {2'b00, frac_q}; end
      MUL_LIM:  begin ma = {2'b00, omega_init_q}; mb = {2'b00, limit_q}; end
      MUL_OG:   begin ma = 25'(err_q); mb = {2'b00, freq_gain_q}; end
      MUL_MU:   begin ma = 25'(err_q); mb = {2'b00, mu_gain_q}; end
      default: ;
    endcase
  end

  // Interpolation finish: a*65536 + (b-a)*mu + half, floor shift
  logic signed [33:0] isum;
  logic signed [15:0] asel;
  assign asel = cmd_i.lat_si ? ai : aq;
  assign isum = {{2{asel[15]}}, asel, 16'h0000} + prod_q[33:0] + 34'sd32768;

  // Timing error
  logic signed [19:0] si_x, sq_x, lr_x, p1i, p1q, p2i, p2q;
  logic signed [19:0] ti, tq, dti, dtq, err_raw, err_cl;
  logic [1:0]         c0, c1, c2;
  assign si_x = 20'(si_q);
  assign sq_x = 20'(sq_q);
  assign lr_x = 20'(lastr_q);
  assign p1i  = 20'($signed(psym_q[0][15:0]));
  assign p1q  = 20'($signed(psym_q[0][31:16]));
  assign p2i  = 20'($signed(psym_q[1][15:0]));
  assign p2q  = 20'($signed(psym_q[1][31:16]));
  assign c0   = {sq_q > 16'sd0, si_q > 16'sd0};
  assign c1   = pdec_q[0];
  assign c2   = pdec_q[1];

  always_comb begin
    ti  = c1[0] ? si_x - p2i : '0;
    tq  = c1[1] ? sq_x - p2q : '0;
    dti = (c0[0] && !c2[0]) ? p1i : ((!c0[0] && c2[0]) ? -p1i : '0);
    dtq = (c0[1] && !c2[1]) ? p1q : ((!c0[1] && c2[1]) ? -p1q : '0);
    if (complex_q) begin
      err_raw = ti + tq - (dti + dtq);
    end else begin
      err_raw = (lr_x < 0 ? -si_x : si_x) - (si_x < 0 ? -lr_x : lr_x);
    end
    if (err_raw > OneQ14) err_cl = OneQ14;
    else if (err_raw < -OneQ14) err_cl = -OneQ14;
    else err_cl = err_raw;
  end

  // Gain term: round half up of product / 16384
  logic signed [32:0] gsum;
  logic signed [18:0] gterm;
  assign gsum  = prod_q[32:0] + 33'sd8192;
  assign gterm = gsum[32:14];

  // Omega update
  logic signed [25:0] om, dev, limx, om2, om_sat;
  always_comb begin
    om   = {3'b000, step_q} + 26'(gterm);
    dev  = om - {3'b000, omega_init_q};
    limx = {3'b000, lim_q};
    if (dev > limx) dev = limx;
    else if (dev < -limx) dev = -limx;
    om2 = {3'b000, omega_init_q} + dev;
    if (om2 < 0) om_sat = '0;
    else if (om2 > {3'b000, OmegaMax}) om_sat = {3'b000, OmegaMax};
    else om_sat = om2;
  end

  // Phase advance
  logic signed [25:0] total;
  assign total = {10'b0, frac_q} + {3'b000, step_q} + 26'(gterm);

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.skip_nz   = skip_q != '0;
  assign status_o.tick_full = tick_q >= 3'd4;
  assign status_o.out_free  = out_free;
  assign status_o.last      = adv_pos_q || (cnt_q == CntW'(MaxSymbols - 1));

  // Control-type state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      complex_q    <= 1'b1;
      omega_init_q <= 23'd131072;
      freq_gain_q  <= 16'd16;
      mu_gain_q    <= 16'd2000;
      limit_q      <= 16'd328;
      frac_q       <= 16'd32768;
      step_q       <= 23'd131072;
      skip_q       <= '0;
      tick_q       <= '0;
      lastr_q      <= '0;
      psym_q[0]    <= '0;
      psym_q[1]    <= '0;
      pdec_q[0]    <= '0;
      pdec_q[1]    <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int k = 0; k < HistoryDepth; k++) hist_q[k] <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegComplexMode:  complex_q <= cfg_data_i[0];
          RegMuInitial:    frac_q    <= cfg_data_i[15:0];
          RegOmegaInitial: begin
            omega_init_q <= cfg_data_i;
            step_q       <= cfg_data_i;
          end
          RegOmegaGain:    freq_gain_q  <= cfg_data_i[15:0];
          RegMuGain:       mu_gain_q    <= cfg_data_i[15:0];
          RegOmegaLimit:   limit_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        for (int k = HistoryDepth - 1; k > 0; k--) hist_q[k] <= hist_q[k-1];
        hist_q[0] <= {sample_q_i, sample_i_i};
      end
      if (cmd_i.skip_dec) skip_q <= skip_q - 8'd1;
      if (cmd_i.start) cnt_q <= '0;
      if (cmd_i.eval) begin
        if (complex_q) begin
          psym_q[1] <= psym_q[0];
          psym_q[0] <= {sq_q, si_q};
          pdec_q[1] <= pdec_q[0];
          pdec_q[0] <= c0;
        end else begin
          lastr_q <= si_q;
        end
        if (tick_q < 3'd4) tick_q <= tick_q + 3'd1;
      end
      if (cmd_i.om_upd) begin
        step_q <= om_sat[22:0];
        tick_q <= '0;
      end
      if (cmd_i.adv) frac_q <= total[15:0];
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
        cnt_q       <= cnt_q + CntW'(1);
        if (adv_pos_q) skip_q <= skip_cand_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= ma * mb;
    if (cmd_i.lat_si) si_q <= isum[31:16];
    if (cmd_i.lat_sq) sq_q <= isum[31:16];
    if (cmd_i.eval) err_q <= err_cl[15:0];
    if (cmd_i.lat_lim) lim_q <= prod_q[38:16];
    if (cmd_i.adv) begin
      adv_pos_q   <= !total[25] && (total[25:16] != '0);
      skip_cand_q <= total[23:16] - 8'd1;
    end
    if (cmd_i.emit) begin
      sym_i_q <= si_q;
      sym_q_q <= complex_q ? sq_q : 16'sd0;
      last_q  <= status_o.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_i_o    = sym_i_q;
  assign symbol_q_o    = sym_q_q;
  assign last_of_run_o = last_q;

endmodule

// ----- hw/rtl/mueller_muller_clock_recovery.sv -----
// Mueller-Muller symbol clock recovery, Q1.14 samples in, symbols out.
// Steps: start, then per symbol interpolate I and Q, latch Q, evaluate, on every fifth symbol
// limit, omega gain and omega update, then mu, advance and emit, via one 25x18 multiplier.
// The input stays closed until a sample's last symbol is emitted or a skipped one passes start;
// output stalls hold the sequencer in its emit step. Up to 4 symbols per sample.
// Reset (async, active low) restores register defaults and the loop state; payload registers are not reset.
module mueller_muller_clock_recovery import mmcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_i_i,
  input  logic signed [15:0] sample_q_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] symbol_i_o,
  output logic signed [15:0] symbol_q_o,
  output logic               last_of_run_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  // Configuration must be written only while idle; the block does not enforce this and always takes the request.
  assign cfg_ready_o = 1'b1;

  // Sequencer: one request at a time, steps the datapath per symbol.
  mmcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath: history line, multiplier, loop filters, output register.
  mmcr_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .sample_i_i    (sample_i_i),
    .sample_q_i    (sample_q_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_i_o    (symbol_i_o),
    .symbol_q_o    (symbol_q_o),
    .last_of_run_o (last_of_run_o)
  );

  // Never overwrite a symbol that still waits to be taken.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || out_ready_i))
    else $error("symbol loaded over a pending one");

  // The final symbol of a run frees the input side next cycle.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit && status.last) |=> in_ready_o)
    else $error("input not released after final symbol");

  // An accepted request keeps the input closed while it is worked on.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input reopened during a request");

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for mueller_muller_clock_recovery: random and directed sample streams.
// Needs mmcr_pkg and the block itself; symbols are predicted in a small scoreboard class.
`timescale 1ns / 1ps

module tb;
  import mmcr_pkg::*;

  typedef struct {
    logic signed [15:0] sym_i;
    logic signed [15:0] sym_q;
    logic               last;
  } symbol_t;

  // Scoreboard: keeps its own copy of the loop state and predicts the symbols
  // of every accepted sample.
  class symbol_scoreboard;
    bit          complex_mode;
    longint      mu_init, omega_center, freq_gain, mu_gain, freq_limit;
    bit   [31:0] hist [HistoryDepth];
    longint      frac_phase, step_omega, skip_count, omega_tick;
    bit   [31:0] prev_sym [2];
    bit   [1:0]  prev_dec [2];
    longint      last_real;
    symbol_t     pending_symbols [$];
    int          errors, symbols_seen;

    function new();
      complex_mode = 1'b1;
      mu_init      = 32768;
      omega_center = 131072;
      freq_gain    = 16;
      mu_gain      = 2000;
      freq_limit   = 328;
      foreach (hist[j]) hist[j] = '0;
      frac_phase   = mu_init;
      step_omega   = omega_center;
      skip_count   = 0;
      omega_tick   = 0;
      prev_sym[0]  = '0;
      prev_sym[1]  = '0;
      prev_dec[0]  = '0;
      prev_dec[1]  = '0;
      last_real    = 0;
      errors       = 0;
      symbols_seen = 0;
    endfunction

    function longint sx(bit [15:0] v);
      return longint'($signed(v));
    endfunction

    function longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint interp(longint a, longint b, longint mu);
      return (a * (65536 - mu) + b * mu + 32768) >>> 16;
    endfunction

    function void write_reg(logic [2:0] idx, logic [22:0] data);
      case (idx)
        RegComplexMode: complex_mode = data[0];
        RegMuInitial: begin
          mu_init    = data[15:0];
          frac_phase = mu_init;
        end
        RegOmegaInitial: begin
          omega_center = data;
          step_omega   = omega_center;
        end
        RegOmegaGain:  freq_gain   = data[15:0];
        RegMuGain:     mu_gain     = data[15:0];
        RegOmegaLimit: freq_limit  = data[15:0];
        default: ;
      endcase
    endfunction

    // Note an accepted sample: shift it in and queue the symbols it yields.
    function void note_sample(logic [15:0] s_i, logic [15:0] s_q);
      longint  ai, aq, bi, bq, si, sq, err, om, lim, total, adv;
      bit [1:0] c0, c1, c2;
      longint  dri, drq;
      int      count;
      symbol_t sym;
      for (int j = HistoryDepth - 1; j > 0; j--) hist[j] = hist[j-1];
      hist[0] = {s_q, s_i};
      if (skip_count > 0) begin
        skip_count--;
        return;
      end
      ai = sx(hist[HistoryDepth-1][15:0]);
      aq = sx(hist[HistoryDepth-1][31:16]);
      bi = sx(hist[NewTap][15:0]);
      bq = sx(hist[NewTap][31:16]);
      count = 0;
      while (count < MaxSymbols) begin
        si = interp(ai, bi, frac_phase);
        sq = interp(aq, bq, frac_phase);
        if (complex_mode) begin
          c0  = {sq > 0, si > 0};
          c1  = prev_dec[0];
          c2  = prev_dec[1];
          dri = longint'(c0[0]) - longint'(c2[0]);
          drq = longint'(c0[1]) - longint'(c2[1]);
          err = (si - sx(prev_sym[1][15:0])) * c1[0] + (sq - sx(prev_sym[1][31:16])) * c1[1]
              - (dri * sx(prev_sym[0][15:0]) + drq * sx(prev_sym[0][31:16]));
          prev_sym[1] = prev_sym[0];
          prev_sym[0] = {sq[15:0], si[15:0]};
          prev_dec[1] = prev_dec[0];
          prev_dec[0] = c0;
        end else begin
          err = (last_real < 0 ? -si : si) - (si < 0 ? -last_real : last_real);
          last_real = si;
          sq = 0;
        end
        err = clip(err, 16384);
        sym.sym_i = si[15:0];
        sym.sym_q = sq[15:0];
        sym.last  = 1'b0;
        pending_symbols.push_back(sym);
        if (omega_tick >= 4) begin
          lim = (freq_limit * omega_center) >> 16;
          om  = step_omega + ((freq_gain * err + 8192) >>> 14);
          om  = omega_center + clip(om - omega_center, lim);
          if (om < 0) om = 0;
          if (om > OmegaMax) om = OmegaMax;
          step_omega = om;
          omega_tick = 0;
        end else begin
          omega_tick++;
        end
        total      = frac_phase + step_omega + ((mu_gain * err + 8192) >>> 14);
        adv        = (total >= 0) ? (total >>> 16) : 0;
        frac_phase = total & 64'hFFFF;
        count++;
        if (adv > 0) begin
          skip_count = (adv - 1) & 8'hFF;
          break;
        end
      end
      pending_symbols[$].last = 1'b1;
    endfunction

    function void check_symbol(logic [15:0] s_i, logic [15:0] s_q, logic last);
      symbol_t want;
      symbols_seen++;
      if (pending_symbols.size() == 0) begin
        $display("%0t: unexpected symbol i=%0d q=%0d last=%0b", $time,
                 $signed(s_i), $signed(s_q), last);
        errors++;
        return;
      end
      want = pending_symbols.pop_front();
      if (s_i !== want.sym_i) begin
        $display("%0t: symbol_i expected %0d got %0d", $time, want.sym_i, $signed(s_i));
        errors++;
      end
      if (s_q !== want.sym_q) begin
        $display("%0t: symbol_q expected %0d got %0d", $time, want.sym_q, $signed(s_q));
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_run expected %0b got %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int WatchdogLimit = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] samp_i = '0;
  logic signed [15:0] samp_q = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] sym_i, sym_q;
  logic               sym_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [22:0]        cfg_data = '0;

  symbol_scoreboard sb = new();
  bit  gaps_on = 1'b1;
  int  hold_cycles = 0;
  int  idle_count = 0;
  int  samples_sent = 0;

  always #5 clk = ~clk;

  mueller_muller_clock_recovery dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_i_i   (samp_i),
    .sample_q_i   (samp_q),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .symbol_i_o   (sym_i),
    .symbol_q_o   (sym_q),
    .last_of_run_o(sym_last),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  // Check every symbol request that completes at a rising edge.
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_symbol(sym_i, sym_q, sym_last);
  end

  // Receiver: random stalls, or one long hold when the stimulus asks for it.
  always begin
    @(negedge clk);
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      repeat (hold_cycles) @(negedge clk);
      hold_cycles = 0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_ready = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    out_ready = 1'b1;
  end

  // Watchdog: end the run when no channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else if (rst_n)
      idle_count <= idle_count + 1;
    if (idle_count >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d symbols outstanding", $time,
               sb.pending_symbols.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [22:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold the sample until accepted; optionally insert an idle burst first.
  task automatic send_sample(logic signed [15:0] s_i, logic signed [15:0] s_q);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    samp_i   = s_i;
    samp_q   = s_q;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s_i, s_q);
    samples_sent++;
  endtask

  // Mostly noisy constellation points so the loop tracks; some raw noise.
  function automatic logic [15:0] pick_level();
    int noise;
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    noise = int'($urandom_range(0, 2000)) - 1000;
    return 16'(($urandom_range(0, 1) ? 12000 : -12000) + noise);
  endfunction

  task automatic send_random(int n);
    repeat (n) send_sample(pick_level(), pick_level());
  endtask

  // Drain all symbols, then allow for samples still being skipped.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending_symbols.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_extremes();
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(-16'sh8000, -16'sh8000);
    send_sample(16'sh7FFF, -16'sh8000);
    send_sample(-16'sh8000, 16'sh7FFF);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(-16'sh0001, 16'sh0001);
    send_sample(16'sh4000, -16'sh4000);
    send_sample(-16'sh4000, 16'sh4000);
  endtask

  initial begin
    int target;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Defaults: complex mode, directed extremes then random.
    send_extremes();
    send_random(40);
    drain();

    // Real mode with zero start phase.
    write_reg(RegComplexMode, 23'd0);
    write_reg(RegMuInitial, 23'd0);
    send_extremes();
    send_random(30);
    drain();

    // Fastest symbol rate, full gains: hits the symbol cap and negative advance.
    // Hold the receiver off meanwhile so the block backs up.
    write_reg(RegComplexMode, 23'd1);
    write_reg(RegMuInitial, 23'd65535);
    write_reg(RegOmegaInitial, 23'd65536);
    write_reg(RegOmegaGain, 23'd65535);
    write_reg(RegMuGain, 23'd65535);
    write_reg(RegOmegaLimit, 23'd65535);
    hold_cycles = 300;
    send_random(60);
    drain();

    // Slowest symbol rate, no loop gain: long skip runs, symbols are rare.
    write_reg(RegOmegaInitial, 23'd4194304);
    write_reg(RegOmegaGain, 23'd0);
    write_reg(RegMuGain, 23'd0);
    write_reg(RegOmegaLimit, 23'd0);
    target = sb.symbols_seen + sb.pending_symbols.size() + 2;
    while (sb.symbols_seen + sb.pending_symbols.size() < target) send_random(1);
    drain();

    // Random settings in both modes.
    repeat (3) begin
      write_reg(RegComplexMode, 23'($urandom_range(0, 1)));
      write_reg(RegMuInitial, 23'($urandom_range(0, 65535)));
      write_reg(RegOmegaInitial, 23'($urandom_range(65536, 300000)));
      write_reg(RegOmegaGain, 23'($urandom_range(0, 65535)));
      write_reg(RegMuGain, 23'($urandom_range(0, 65535)));
      write_reg(RegOmegaLimit, 23'($urandom_range(0, 65535)));
      send_random(25);
      drain();
    end

    // Final stretch at full rate on both sides.
    gaps_on = 1'b0;
    write_reg(RegComplexMode, 23'd1);
    write_reg(RegOmegaInitial, 23'd131072);
    write_reg(RegMuGain, 23'd2000);
    write_reg(RegOmegaGain, 23'd16);
    write_reg(RegOmegaLimit, 23'd328);
    send_random(30);
    drain();

    $display("Ran %0d samples through real and complex modes, %0d symbols checked,",
             samples_sent, sb.symbols_seen);
    $display("covering symbol cap, long skips, receiver hold-off and extreme settings.");
    if (sb.errors == 0 && sb.pending_symbols.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
